/* rtl/ctf_pkg.sv */
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared constants, types and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
`default_nettype none
package ctf_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_LEN   = 24;
  localparam int CW         = 38;   // CORDIC vector width
  localparam int ZW         = 32;   // CORDIC angle width
  localparam int GW         = 42;   // gyro-path term width
  localparam int AW         = 40;   // scaled accelerometer angle width
  localparam int MW         = 60;   // blend accumulator width
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [ZW-1:0] QUARTER_TURN   = 32'sd377487360;
  localparam logic signed [31:0]   CORDIC_GAIN_Q30 = 32'sd1768195363;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 8'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;
  localparam logic [23:0] GYRO_GAIN_RST    = 24'd81966;

  typedef enum logic [2:0] {
    S_IDLE, S_PASS1, S_SCALE, S_PASS2, S_ROUND, S_BLEND, S_OUT
  } ctf_state_t;

  typedef struct packed {
    logic start;
    logic done;
  } ctf_unit_ctl_t;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'sd188743680;
      5'd1:  v = 32'sd111421900;
      5'd2:  v = 32'sd58872272;
      5'd3:  v = 32'sd29884485;
      5'd4:  v = 32'sd15000234;
      5'd5:  v = 32'sd7507429;
      5'd6:  v = 32'sd3754631;
      5'd7:  v = 32'sd1877430;
      5'd8:  v = 32'sd938729;
      5'd9:  v = 32'sd469366;
      5'd10: v = 32'sd234683;
      5'd11: v = 32'sd117342;
      5'd12: v = 32'sd58671;
      5'd13: v = 32'sd29335;
      5'd14: v = 32'sd14668;
      5'd15: v = 32'sd7334;
      5'd16: v = 32'sd3667;
      5'd17: v = 32'sd1833;
      5'd18: v = 32'sd917;
      5'd19: v = 32'sd458;
      5'd20: v = 32'sd229;
      5'd21: v = 32'sd115;
      5'd22: v = 32'sd57;
      5'd23: v = 32'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/ctf_if.sv */
// ----------------------------------------------------------------------------
// ctf_if
// Channel interfaces: sample input, filtered result and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface ctf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, output ready);
endinterface

interface ctf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_out;
  logic signed [15:0] roll_out;
  logic signed [14:0] grav_pitch_out;
  logic signed [13:0] grav_roll_out;
  modport source (output valid, pitch_out, roll_out, grav_pitch_out, grav_roll_out,
                  input ready);
  modport sink   (input valid, pitch_out, roll_out, grav_pitch_out, grav_roll_out,
                  output ready);
endinterface

interface ctf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/ctf_cordic.sv */
// ----------------------------------------------------------------------------
// ctf_cordic
// Vectoring CORDIC, one micro-rotation per cycle, reused for both passes.
// ----------------------------------------------------------------------------
`default_nettype none
module ctf_cordic
  import ctf_pkg::*;
#(
  parameter int ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctf_unit_ctl_t        ctl_in,
  output      ctf_unit_ctl_t        ctl_out,
  input  wire logic signed [CW-1:0] x0,
  input  wire logic signed [CW-1:0] y0,
  output      logic signed [CW-1:0] mag,
  output      logic signed [ZW-1:0] angle
);
  localparam int NI = (ITERATIONS > ATAN_LEN) ? ATAN_LEN : ITERATIONS;

  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0]           i_r;
  logic                 busy_r, zero_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        zero_r <= (x0 == '0) && (y0 == '0);
        if (x0 < 0) begin
          if (y0 >= 0) begin
            x_r <= y0; y_r <= -x0; z_r <= QUARTER_TURN;
          end else begin
            x_r <= -y0; y_r <= x0; z_r <= -QUARTER_TURN;
          end
        end else begin
          x_r <= x0; y_r <= y0; z_r <= '0;
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_entry(i_r);
        end else begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_entry(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(NI - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign mag           = zero_r ? '0 : x_r;
  assign angle         = zero_r ? '0 : z_r;
  assign ctl_out.done  = done_r;
  assign ctl_out.start = 1'b0;
endmodule
`default_nettype wire

/* rtl/ctf_blend.sv */
// ----------------------------------------------------------------------------
// ctf_blend
// Bit-serial weighted blend: alpha*G + (1-alpha)*A, one weight bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ctf_blend
  import ctf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctf_unit_ctl_t        ctl_in,
  output      ctf_unit_ctl_t        ctl_out,
  input  wire logic signed [GW-1:0] g,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [15:0]          alpha,
  output      logic signed [15:0]   result
);
  logic signed [MW-1:0] acc_r, acc_nxt;
  logic [16:0]          wa_r, wb_r;
  logic [4:0]           k_r;
  logic                 busy_r, done_r;
  logic signed [MW-1:0] rnd;
  logic signed [19:0]   q;

  always_comb begin
    acc_nxt = (acc_r <<< 1)
            + (wa_r[16] ? MW'(g) : '0)
            + (wb_r[16] ? MW'(a) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        wa_r   <= {1'b0, alpha};
        wb_r   <= 17'h10000 - {1'b0, alpha};
        k_r    <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        wa_r  <= wa_r << 1;
        wb_r  <= wb_r << 1;
        k_r   <= k_r + 5'd1;
        if (k_r == 5'd16) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rnd = acc_r + (MW'(1) <<< 39);
    q   = 20'(rnd >>> 40);
    if (q > 20'sd32767)       result = 16'sh7FFF;
    else if (q < -20'sd32768) result = 16'sh8000;
    else                      result = q[15:0];
  end

  assign ctl_out.done  = done_r;
  assign ctl_out.start = 1'b0;
endmodule
`default_nettype wire

/* rtl/complementary_tilt_filter_unit.sv */
// ----------------------------------------------------------------------------
// complementary_tilt_filter_unit
// Pitch and roll complementary filter from raw accelerometer and gyro samples.
// ----------------------------------------------------------------------------
// The unit works on one sample at a time. A sample transfer is taken only
// while the unit is idle; it then runs a vectoring CORDIC on (accel_z,
// accel_y) for the accelerometer pitch, scales -accel_x by the CORDIC gain and
// runs the same CORDIC unit again on (magnitude, scaled x) for the roll. Each
// pass runs CORDIC_ITERATIONS micro-rotations (capped at 24), and these
// dominate the latency. The angles are then rounded to 1/64 degree and the
// two blends run bit-serially over the 17-bit weights, in parallel for pitch
// and roll. The result sits in an output register, and the unit is ready
// for the next sample as soon as the result is loaded, even while it waits
// to be taken. Register writes must only be made while the unit is idle;
// register 0 is the blend weight alpha (Q0.16) and register 1 the gyro step
// gain (Q0.24).
// ----------------------------------------------------------------------------
`default_nettype none
module complementary_tilt_filter_unit
  import ctf_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ctf_in_if.sink    in_ch,
  ctf_out_if.source out_ch,
  ctf_cfg_if.sink   cfg_ch
);

  ctf_state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] blend_weight_r;
  logic [23:0] gyro_gain_r;

  // Filter state.
  logic signed [15:0] pitch_r, roll_r;

  // Sample and intermediate registers.
  logic signed [15:0]   ax_r, rx_r, ry_r;
  logic signed [CW-1:0] mag_r;
  logic signed [ZW-1:0] zp_r, zr_r;
  logic signed [48:0]   prod_r;
  logic signed [GW-1:0] gp_r, gr_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] out_pitch_r, out_roll_r;
  logic signed [14:0] out_accp_r;
  logic signed [13:0] out_accr_r;

  ctf_unit_ctl_t cor_in, cor_out, bp_in, bp_out, br_in, br_out;
  logic signed [CW-1:0] cor_x0, cor_y0, cor_mag;
  logic signed [ZW-1:0] cor_angle;
  logic signed [15:0]   new_pitch, new_roll;
  logic signed [32:0]   zp_rnd, zr_rnd;
  logic signed [16:0]   zp_q, zr_q;
  logic                 in_fire, out_load;
  logic                 blend_pair_done;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Both blends start together and take the same number of cycles, so the
  // roll done flag only confirms the pitch one.
  assign blend_pair_done = bp_out.done && br_out.done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= BLEND_WEIGHT_RST;
      gyro_gain_r    <= GYRO_GAIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_BLEND_WEIGHT: blend_weight_r <= cfg_ch.data[15:0];
        REG_GYRO_GAIN:    gyro_gain_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cor_in.start = 1'b0;
    cor_in.done  = 1'b0;
    bp_in.start  = 1'b0;
    bp_in.done   = 1'b0;
    cor_x0 = {{(CW-32){in_ch.accel_z[15]}}, in_ch.accel_z, 16'b0};
    cor_y0 = {{(CW-32){in_ch.accel_y[15]}}, in_ch.accel_y, 16'b0};
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cor_in.start = 1'b1;
          state_nxt    = S_PASS1;
        end
      end
      S_PASS1: if (cor_out.done) state_nxt = S_SCALE;
      S_SCALE: begin
        // Second pass: the pitch magnitude against -accel_x times the gain.
        cor_x0       = mag_r;
        cor_y0       = CW'(prod_r >>> 14);
        cor_in.start = 1'b1;
        state_nxt    = S_PASS2;
      end
      S_PASS2: if (cor_out.done) state_nxt = S_ROUND;
      S_ROUND: begin
        bp_in.start = 1'b1;
        state_nxt   = S_BLEND;
      end
      S_BLEND: if (blend_pair_done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    br_in = bp_in;
  end

  // Rounding of the CORDIC angles to 1/64 degree with range clamps.
  always_comb begin
    zp_rnd = 33'(zp_r) + 33'sd32768;
    zr_rnd = 33'(zr_r) + 33'sd32768;
    zp_q   = 17'(zp_rnd >>> 16);
    zr_q   = 17'(zr_rnd >>> 16);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax_r <= in_ch.accel_x;
      rx_r <= in_ch.rate_x;
      ry_r <= in_ch.rate_y;
    end
    if (state_r == S_PASS1 && cor_out.done) begin
      mag_r  <= cor_mag;
      zp_r   <= cor_angle;
      prod_r <= 49'((-(17'(ax_r))) * CORDIC_GAIN_Q30);
    end
    if (state_r == S_PASS2 && cor_out.done) begin
      zr_r <= cor_angle;
      gp_r <= (GW'(pitch_r) <<< 24) + GW'(rx_r * $signed({1'b0, gyro_gain_r}));
      gr_r <= (GW'(roll_r) <<< 24) + GW'(ry_r * $signed({1'b0, gyro_gain_r}));
    end
  end

  // Clamped accelerometer angles are taken once both passes are finished.
  logic signed [14:0] acc_p_val;
  logic signed [13:0] acc_r_val;
  always_comb begin
    if (zp_q > 17'sd11520)       acc_p_val = 15'sd11520;
    else if (zp_q < -17'sd11520) acc_p_val = -15'sd11520;
    else                         acc_p_val = zp_q[14:0];
    if (zr_q > 17'sd5760)        acc_r_val = 14'sd5760;
    else if (zr_q < -17'sd5760)  acc_r_val = -14'sd5760;
    else                         acc_r_val = zr_q[13:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r     <= '0;
      roll_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b1;
        pitch_r     <= new_pitch;
        roll_r      <= new_roll;
        out_pitch_r <= new_pitch;
        out_roll_r  <= new_roll;
        out_accp_r  <= acc_p_val;
        out_accr_r  <= acc_r_val;
      end
    end
  end

  ctf_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (cor_in),
    .ctl_out (cor_out),
    .x0      (cor_x0),
    .y0      (cor_y0),
    .mag     (cor_mag),
    .angle   (cor_angle)
  );

  ctf_blend u_blend_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (bp_in),
    .ctl_out (bp_out),
    .g       (gp_r),
    .a       (AW'(acc_p_val) <<< 24),
    .alpha   (blend_weight_r),
    .result  (new_pitch)
  );

  ctf_blend u_blend_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (br_in),
    .ctl_out (br_out),
    .g       (gr_r),
    .a       (AW'(acc_r_val) <<< 24),
    .alpha   (blend_weight_r),
    .result  (new_roll)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pitch_out      = out_pitch_r;
  assign out_ch.roll_out       = out_roll_r;
  assign out_ch.grav_pitch_out = out_accp_r;
  assign out_ch.grav_roll_out  = out_accr_r;

endmodule
`default_nettype wire
